/* rtl/fsa_pkg.sv */
// Shared types, status and strategy codes for the segment allocator.
package fsa_pkg;

    localparam int unsigned MaxSegmentsDef = 16;
    localparam int unsigned PoolSizeDef    = 1024;

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_SIZE = 2'd3;

    localparam logic [1:0] FIT_BEST  = 2'd0;
    localparam logic [1:0] FIT_FIRST = 2'd1;
    localparam logic [1:0] FIT_NEXT  = 2'd2;
    localparam logic [1:0] FIT_WORST = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic init;      // load the scan pointer and clear the pick
        logic scan;      // examine one entry
        logic shift;     // move one entry up by one
        logic write;     // write chosen entry and remainder
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;   // last entry examined
        logic found;       // a fitting entry was picked
        logic need_split;  // picked entry is longer than request
        logic full;        // table has no room for a split
        logic shift_done;  // all entries above the pick moved
    } t_stat;

endpackage

/* rtl/fsa_datapath.sv */
// Segment table, scan unit and split/shift logic of the allocator.
module fsa_datapath import fsa_pkg::*; #(
    parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef,
    parameter int unsigned POOL_SIZE    = PoolSizeDef,
    localparam int unsigned IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_strategy,
    input  logic [10:0] i_size,
    output t_stat       o_stat,
    output logic [9:0]  o_offset
);

    logic [9:0]              r_start [MAX_SEGMENTS];
    logic [10:0]             r_len   [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] r_used;
    logic [CW-1:0]           r_count;
    logic [IW-1:0]           r_rover;
    logic [IW-1:0]           r_pos;
    logic [CW-1:0]           r_steps;
    logic                    r_found;
    logic [IW-1:0]           r_pick;
    logic [10:0]             r_pick_len;
    logic [9:0]              r_pick_start;
    logic [CW-1:0]           r_k;

    logic          fits;
    logic          better;
    logic [CW-1:0] pos_inc;
    logic [CW-1:0] pick_inc;
    logic [IW-1:0] k_idx;

    assign fits = !r_used[r_pos] && (r_len[r_pos] >= i_size);
    assign pos_inc  = CW'(r_pos) + CW'(1);
    assign pick_inc = CW'(r_pick) + CW'(1);
    assign k_idx = r_k[IW-1:0];

    always_comb begin
        unique case (i_strategy)
            FIT_BEST:  better = !r_found || (r_len[r_pos] < r_pick_len);
            FIT_WORST: better = !r_found || (r_len[r_pos] > r_pick_len);
            default:   better = !r_found;
        endcase
    end

    assign o_stat.scan_done  = (r_steps == CW'(1));
    assign o_stat.found      = r_found;
    assign o_stat.need_split = (r_pick_len > i_size);
    assign o_stat.full       = (r_count == CW'(MAX_SEGMENTS));
    assign o_stat.shift_done = (r_k <= pick_inc);
    assign o_offset          = r_pick_start;

    // Table contents: payload only, entry 0 seeded by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start[0] <= '0;
            r_len[0]   <= 11'(POOL_SIZE);
        end else if (i_cmd.shift) begin
            r_start[k_idx] <= r_start[k_idx - IW'(1)];
            r_len[k_idx]   <= r_len[k_idx - IW'(1)];
        end else if (i_cmd.write) begin
            r_len[r_pick] <= i_size;
            if (r_pick_len > i_size) begin
                r_start[IW'(pick_inc)] <= r_pick_start + i_size[9:0];
                r_len[IW'(pick_inc)]   <= r_pick_len - i_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= CW'(1);
            r_rover <= '0;
            r_pos   <= '0;
            r_steps <= '0;
            r_found <= 1'b0;
            r_pick  <= '0;
            r_k     <= '0;
        end else begin
            if (i_cmd.init) begin
                r_pos   <= (i_strategy == FIT_NEXT && CW'(r_rover) < r_count) ? r_rover : '0;
                r_steps <= r_count;
                r_found <= 1'b0;
                r_k     <= r_count;
            end else if (i_cmd.scan) begin
                if (fits && better && !(i_strategy == FIT_FIRST && r_found)
                        && !(i_strategy == FIT_NEXT && r_found)) begin
                    r_found      <= 1'b1;
                    r_pick       <= r_pos;
                    r_pick_len   <= r_len[r_pos];
                    r_pick_start <= r_start[r_pos];
                end
                r_pos   <= (pos_inc >= r_count) ? '0 : IW'(pos_inc);
                r_steps <= r_steps - CW'(1);
            end else if (i_cmd.shift) begin
                r_used[k_idx] <= r_used[k_idx - IW'(1)];
                r_k <= r_k - CW'(1);
            end else if (i_cmd.write) begin
                r_used[r_pick] <= 1'b1;
                if (r_pick_len > i_size) begin
                    r_used[IW'(pick_inc)] <= 1'b0;
                    r_count <= r_count + CW'(1);
                    r_rover <= (pick_inc < r_count + CW'(1)) ? IW'(pick_inc) : '0;
                end else begin
                    r_rover <= (pick_inc < r_count) ? IW'(pick_inc) : '0;
                end
            end
        end
    end

endmodule

/* rtl/fsa_ctrl.sv */
// Request sequencer of the allocator: scan, shift, write, respond.
module fsa_ctrl import fsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic [10:0] i_req_size,
    output logic        o_req_ready,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic        o_res_load,
    output logic [1:0]  o_res_status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0] r_state, n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_res_load   = 1'b0;
        o_res_status = ST_GRANTED;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_size == '0) begin
                        o_res_load   = 1'b1;
                        o_res_status = ST_BAD_SIZE;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) n_state = S_DEC;
            end
            S_DEC: begin
                if (!i_stat.found) begin
                    o_res_load   = 1'b1;
                    o_res_status = ST_NO_FIT;
                    n_state      = S_IDLE;
                end else if (i_stat.need_split && i_stat.full) begin
                    o_res_load   = 1'b1;
                    o_res_status = ST_FULL;
                    n_state      = S_IDLE;
                end else if (i_stat.need_split) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) n_state = S_WRITE;
                else o_cmd.shift = 1'b1;
            end
            S_WRITE: begin
                o_cmd.write  = 1'b1;
                o_res_load   = 1'b1;
                o_res_status = ST_GRANTED;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

/* rtl/fit_strategy_segment_allocator_core.sv */
// Top level of the fit-strategy segment allocator.
// From the accepting edge to the edge that loads the result a request
// passes through set-up, a scan of every segment in the table, a decision,
// for a split a shift of each entry above the chosen one, and a write; the
// scan and the shift each handle one table entry per cycle. A zero size is
// answered at the accepting edge, without a scan. The result sits in an
// output register; a new request is taken only while that register is
// empty or being emptied, so a waiting result holds off the input. The
// strategy register is written through its own channel, always ready.
// Segments are never freed.
module fit_strategy_segment_allocator_core import fsa_pkg::*; #(
    parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef,
    parameter int unsigned POOL_SIZE    = PoolSizeDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,      // [1:0] fit_strategy
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [10:0] request_size
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata     // [1:0] status, [11:2] grant_offset
);

    t_cmd       cmd;
    t_stat      stat;
    logic       req_ready;
    logic       res_load;
    logic [1:0] res_status;
    logic [9:0] offset;
    logic [1:0] r_strategy;
    logic [10:0] r_size;
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [9:0] r_out_offset;
    logic       out_free;

    // Hold off new requests until the output slot is free.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = req_ready && out_free;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strategy <= FIT_FIRST;
        else if (i_cfg_valid) r_strategy <= i_cfg_data[1:0];
    end

    // Capture the size on accept.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_size <= s_axis_tdata[10:0];
    end

    fsa_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid && out_free),
        .i_req_size   (s_axis_tdata[10:0]),
        .o_req_ready  (req_ready),
        .i_stat       (stat),
        .o_cmd        (cmd),
        .o_res_load   (res_load),
        .o_res_status (res_status)
    );

    fsa_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .POOL_SIZE    (POOL_SIZE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_strategy (r_strategy),
        .i_size     (r_size),
        .o_stat     (stat),
        .o_offset   (offset)
    );

    // Output register: load on result, drop on take.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_status <= res_status;
            r_out_offset <= (res_status == ST_GRANTED) ? offset : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_offset, r_out_status};

`ifndef SYNTHESIS
    // A result is only loaded while the output slot can take it.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> out_free) else $error("result overwrote a waiting one");
    // A refused request reports offset zero.
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_GRANTED) |-> m_axis_tdata[11:2] == '0)
        else $error("nonzero offset on refusal");
    // No request is taken while the sequencer scans or shifts.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.scan || cmd.shift) |-> !s_axis_tready) else $error("accepted while busy");
`endif

endmodule
